FILE: hw/rtl/rbtd_pkg.sv
`default_nettype none

package rbtd_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned RATE_W     = 10;
  localparam int unsigned BUDGET_W   = 20;
  localparam int unsigned ELAPSED_W  = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned LOOPCNT_W  = 16;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned TASKCNT_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Shared divider: 32-bit dividend, 10-bit divisor, up to 32 steps
  localparam int unsigned DVD_W   = 32;
  localparam int unsigned DSR_W   = 10;
  localparam int unsigned STEPS_W = 6;

  localparam logic [RATE_W-1:0] LOOP_RATE_RST = 10'd100;

  // Dividends are placed at the top of the dividend word, one step per bit
  localparam logic [DVD_W-1:0]   MS_PER_S_ALIGNED = 32'd1000 << 22;
  localparam logic [STEPS_W-1:0] MS_PER_S_STEPS   = 6'd10;
  localparam logic [DVD_W-1:0]   US_PER_S_ALIGNED = 32'd1000000 << 12;
  localparam logic [STEPS_W-1:0] US_PER_S_STEPS   = 6'd20;
  localparam int unsigned        RATE_SHIFT       = DVD_W - RATE_W;
  localparam logic [STEPS_W-1:0] RATE_STEPS       = 6'd10;
  localparam logic [STEPS_W-1:0] TICK_STEPS       = 6'd32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK = 2'd0,
    OP_LOOP = 2'd1,
    OP_DONE = 2'd2,
    OP_LOAD = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE      = 2'd0,
    KIND_LOOP_DUE  = 2'd1,
    KIND_DISPATCH  = 2'd2,
    KIND_SCAN_DONE = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_RATE  = 2'd0,
    CFG_TASK_COUNT = 2'd1,
    CFG_SPARE2     = 2'd2,
    CFG_SPARE3     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                start;
    logic [DVD_W-1:0]    dividend;
    logic [DSR_W-1:0]    divisor;
    logic [STEPS_W-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DVD_W-1:0]   quo;
    logic [DSR_W-1:0]   rem;
  } div_rsp_t;

  typedef struct packed {
    logic [RATE_W-1:0]    rate;
    logic [BUDGET_W-1:0]  budget;
    logic [LOOPCNT_W-1:0] last;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rbtd_if.sv
`default_nettype none

interface rbtd_in_if;
  logic                            valid;
  logic                            ready;
  logic [rbtd_pkg::OPCODE_W-1:0]   opcode;
  logic [rbtd_pkg::SLOT_W-1:0]     task_slot;
  logic [rbtd_pkg::RATE_W-1:0]     task_rate_hz;
  logic [rbtd_pkg::BUDGET_W-1:0]   task_budget_us;
  logic [rbtd_pkg::ELAPSED_W-1:0]  elapsed_us;

  modport source (output valid, opcode, task_slot, task_rate_hz, task_budget_us, elapsed_us,
                  input ready);
  modport sink   (input valid, opcode, task_slot, task_rate_hz, task_budget_us, elapsed_us,
                  output ready);
endinterface

interface rbtd_out_if;
  logic                           valid;
  logic                           ready;
  logic [rbtd_pkg::KIND_W-1:0]    result_kind;
  logic [rbtd_pkg::SLOT_W-1:0]    dispatch_slot;
  logic [rbtd_pkg::BUDGET_W-1:0]  time_left_us;

  modport source (output valid, result_kind, dispatch_slot, time_left_us, input ready);
  modport sink   (input valid, result_kind, dispatch_slot, time_left_us, output ready);
endinterface

interface rbtd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rbtd_pkg::CFG_IDX_W-1:0]   index;
  logic [rbtd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rbtd_div.sv
`default_nettype none

module rbtd_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rbtd_pkg::div_req_t req_i,
  output rbtd_pkg::div_rsp_t      rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [rbtd_pkg::STEPS_W-1:0]   cnt_q, cnt_d;
  logic [rbtd_pkg::DVD_W-1:0]     dvd_q, dvd_d;
  logic [rbtd_pkg::DSR_W-1:0]     rem_q, rem_d;
  logic [rbtd_pkg::DSR_W-1:0]     dsr_q, dsr_d;
  logic [rbtd_pkg::DSR_W:0]       trial;
  logic                           fits;

  // One restoring step: remainder stays below the divisor, so 10 bits hold it
  assign trial = {rem_q, dvd_q[rbtd_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? rbtd_pkg::DSR_W'(trial - {1'b0, dsr_q}) : trial[rbtd_pkg::DSR_W-1:0];
      dvd_d = {dvd_q[rbtd_pkg::DVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rbtd_pkg::STEPS_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rbtd_table.sv
`default_nettype none

module rbtd_table #(
  parameter int unsigned DEPTH = rbtd_pkg::MAX_TASKS_DEF,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            rd_en_i,
  input  wire logic [IDX_W-1:0]                rd_addr_i,
  input  wire logic                            ld_en_i,
  input  wire logic [IDX_W-1:0]                ld_addr_i,
  input  wire logic [rbtd_pkg::RATE_W-1:0]     ld_rate_i,
  input  wire logic [rbtd_pkg::BUDGET_W-1:0]   ld_budget_i,
  input  wire logic                            run_en_i,
  input  wire logic [IDX_W-1:0]                run_addr_i,
  input  wire logic [rbtd_pkg::LOOPCNT_W-1:0]  run_loop_i,
  output rbtd_pkg::entry_t                     entry_o
);

  logic [rbtd_pkg::RATE_W+rbtd_pkg::BUDGET_W-1:0] cfg_mem [DEPTH];
  logic [rbtd_pkg::LOOPCNT_W-1:0]                 last_mem [DEPTH];
  logic [DEPTH-1:0]                               last_vld_q;

  logic [rbtd_pkg::RATE_W+rbtd_pkg::BUDGET_W-1:0] cfg_rd_q;
  logic [rbtd_pkg::LOOPCNT_W-1:0]                 last_rd_q;
  logic                                           last_vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (ld_en_i) begin
      cfg_mem[ld_addr_i] <= {ld_rate_i, ld_budget_i};
    end
    if (run_en_i) begin
      last_mem[run_addr_i] <= run_loop_i;
    end
    if (rd_en_i) begin
      cfg_rd_q  <= cfg_mem[rd_addr_i];
      last_rd_q <= last_mem[rd_addr_i];
    end
  end

  // Last-run loop resets to zero: an entry never run reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_vld_q    <= '0;
      last_vld_rd_q <= 1'b0;
    end else begin
      if (run_en_i) begin
        last_vld_q[run_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        last_vld_rd_q <= last_vld_q[rd_addr_i];
      end
    end
  end

  assign entry_o.rate   = cfg_rd_q[rbtd_pkg::RATE_W+rbtd_pkg::BUDGET_W-1:rbtd_pkg::BUDGET_W];
  assign entry_o.budget = cfg_rd_q[rbtd_pkg::BUDGET_W-1:0];
  assign entry_o.last   = last_vld_rd_q ? last_rd_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/rate_based_task_dispatcher.sv
`default_nettype none

// Channel   Port   Dir  Payload
// input     in_i   in   opcode, task_slot, task_rate_hz, task_budget_us, elapsed_us
// result    out_o  out  result_kind, dispatch_slot, time_left_us
// config    cfg_i  in   index (0 loop_rate_hz, 1 task_count), data
//
// One item at a time; one shared 1-bit-per-cycle divider sets the latency.
// Load writes the addressed table entry. Tick runs a 10-step and a 32-step division.
// Loop start runs one division for the loop period, then one 10-step division
// per table entry examined; task finished runs one such division per entry examined.
// Reset clears counters, flags and last-run marks at once; no clearing pass.
// A finished result waits in the output register; the next item is accepted
// meanwhile and only its own result stalls behind an unaccepted one.

module rate_based_task_dispatcher #(
  parameter int unsigned MAX_TASKS = rbtd_pkg::MAX_TASKS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rbtd_in_if.sink    in_i,
  rbtd_out_if.source out_o,
  rbtd_cfg_if.sink   cfg_i
);

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_TICK_PER   = 8'b0000_0010,
    S_TICK_MOD   = 8'b0000_0100,
    S_LOOP_DIV   = 8'b0000_1000,
    S_SCAN_CHECK = 8'b0001_0000,
    S_SCAN_READ  = 8'b0010_0000,
    S_SCAN_DIV   = 8'b0100_0000,
    S_EMIT       = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [rbtd_pkg::RATE_W-1:0]     loop_rate_q, loop_rate_d;
  logic [rbtd_pkg::TASKCNT_W-1:0]  task_cnt_q, task_cnt_d;
  logic [rbtd_pkg::TICK_W-1:0]     tick_q, tick_d;
  logic [rbtd_pkg::LOOPCNT_W-1:0]  loop_cnt_q, loop_cnt_d;
  logic                            pend_q, pend_d;
  logic                            await_q, await_d;
  logic [CNT_W-1:0]                pos_q, pos_d;
  logic [rbtd_pkg::BUDGET_W-1:0]   budget_q, budget_d;
  logic [rbtd_pkg::ELAPSED_W-1:0]  elapsed_q, elapsed_d;

  rbtd_pkg::kind_e                 res_kind_q, res_kind_d;
  logic [rbtd_pkg::SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic [rbtd_pkg::BUDGET_W-1:0]   res_left_q, res_left_d;

  logic                            out_valid_q, out_valid_d;
  rbtd_pkg::kind_e                 out_kind_q, out_kind_d;
  logic [rbtd_pkg::SLOT_W-1:0]     out_slot_q, out_slot_d;
  logic [rbtd_pkg::BUDGET_W-1:0]   out_left_q, out_left_d;

  rbtd_pkg::div_req_t              div_req;
  rbtd_pkg::div_rsp_t              div_rsp;
  rbtd_pkg::entry_t                entry;

  logic                            rd_en;
  logic                            ld_en;
  logic                            run_en;

  logic                            in_acc;
  logic [rbtd_pkg::RATE_W-1:0]     eff_rate;
  logic [rbtd_pkg::RATE_W-1:0]     task_rate;
  logic [rbtd_pkg::RATE_W-1:0]     quo_min1;
  logic [rbtd_pkg::BUDGET_W-1:0]   period_us;
  logic [rbtd_pkg::LOOPCNT_W-1:0]  since_run;
  logic [CNT_W-1:0]                limit;
  rbtd_pkg::op_e                   op;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign op          = rbtd_pkg::op_e'(in_i.opcode);

  assign eff_rate  = (loop_rate_q == '0) ? rbtd_pkg::RATE_W'(1) : loop_rate_q;
  assign task_rate = (entry.rate == '0) ? rbtd_pkg::RATE_W'(1) : entry.rate;
  assign quo_min1  = (div_rsp.quo[rbtd_pkg::RATE_W-1:0] == '0) ? rbtd_pkg::RATE_W'(1)
                                                            : div_rsp.quo[rbtd_pkg::RATE_W-1:0];
  assign period_us = div_rsp.quo[rbtd_pkg::BUDGET_W-1:0];
  assign since_run = loop_cnt_q - entry.last;
  assign limit     = (32'(task_cnt_q) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_cnt_q);

  // Configuration registers
  always_comb begin
    loop_rate_d = loop_rate_q;
    task_cnt_d  = task_cnt_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (rbtd_pkg::cfg_idx_e'(cfg_i.index))
        rbtd_pkg::CFG_LOOP_RATE:  loop_rate_d = cfg_i.data[rbtd_pkg::RATE_W-1:0];
        rbtd_pkg::CFG_TASK_COUNT: task_cnt_d  = cfg_i.data[rbtd_pkg::TASKCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    tick_d     = tick_q;
    loop_cnt_d = loop_cnt_q;
    pend_d     = pend_q;
    await_d    = await_q;
    pos_d      = pos_q;
    budget_d   = budget_q;
    elapsed_d  = elapsed_q;
    res_kind_d = res_kind_q;
    res_slot_d = res_slot_q;
    res_left_d = res_left_q;

    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_slot_d  = out_slot_q;
    out_left_d  = out_left_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    div_req = '0;
    rd_en   = 1'b0;
    ld_en   = 1'b0;
    run_en  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          elapsed_d  = in_i.elapsed_us;
          res_kind_d = rbtd_pkg::KIND_NONE;
          res_slot_d = '0;
          res_left_d = '0;
          state_d    = S_EMIT;
          case (op)
            rbtd_pkg::OP_TICK: begin
              div_req.start    = 1'b1;
              div_req.dividend = rbtd_pkg::MS_PER_S_ALIGNED;
              div_req.divisor  = eff_rate;
              div_req.steps    = rbtd_pkg::MS_PER_S_STEPS;
              state_d          = S_TICK_PER;
            end
            rbtd_pkg::OP_LOOP: begin
              if (pend_q && !await_q) begin
                pend_d           = 1'b0;
                loop_cnt_d       = loop_cnt_q + 1'b1;
                div_req.start    = 1'b1;
                div_req.dividend = rbtd_pkg::US_PER_S_ALIGNED;
                div_req.divisor  = eff_rate;
                div_req.steps    = rbtd_pkg::US_PER_S_STEPS;
                state_d          = S_LOOP_DIV;
              end
            end
            rbtd_pkg::OP_DONE: begin
              if (await_q) begin
                await_d = 1'b0;
                if (in_i.elapsed_us >= 32'(budget_q)) begin
                  // Overrun: end the scan and flag the next loop
                  budget_d   = '0;
                  pend_d     = 1'b1;
                  res_kind_d = rbtd_pkg::KIND_LOOP_DUE;
                end else begin
                  budget_d = budget_q - in_i.elapsed_us[rbtd_pkg::BUDGET_W-1:0];
                  state_d  = S_SCAN_CHECK;
                end
              end
            end
            rbtd_pkg::OP_LOAD: begin
              ld_en = (32'(in_i.task_slot) < MAX_TASKS);
            end
            default: ;
          endcase
        end
      end

      S_TICK_PER: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = tick_q;
          div_req.divisor  = quo_min1;
          div_req.steps    = rbtd_pkg::TICK_STEPS;
          state_d          = S_TICK_MOD;
        end
      end

      S_TICK_MOD: begin
        if (div_rsp.done) begin
          tick_d = tick_q + 1'b1;
          if (div_rsp.rem == '0) begin
            pend_d     = 1'b1;
            res_kind_d = rbtd_pkg::KIND_LOOP_DUE;
          end
          state_d = S_EMIT;
        end
      end

      S_LOOP_DIV: begin
        if (div_rsp.done) begin
          budget_d = (32'(period_us) > elapsed_q)
                     ? period_us - elapsed_q[rbtd_pkg::BUDGET_W-1:0] : '0;
          pos_d    = '0;
          state_d  = S_SCAN_CHECK;
        end
      end

      S_SCAN_CHECK: begin
        if (pos_q >= limit) begin
          pos_d      = limit;
          res_kind_d = rbtd_pkg::KIND_SCAN_DONE;
          res_slot_d = '0;
          res_left_d = budget_q;
          state_d    = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          state_d = S_SCAN_READ;
        end
      end

      S_SCAN_READ: begin
        div_req.start    = 1'b1;
        div_req.dividend = {eff_rate, (rbtd_pkg::RATE_SHIFT)'(0)};
        div_req.divisor  = task_rate;
        div_req.steps    = rbtd_pkg::RATE_STEPS;
        state_d          = S_SCAN_DIV;
      end

      S_SCAN_DIV: begin
        if (div_rsp.done) begin
          if (since_run >= rbtd_pkg::LOOPCNT_W'(quo_min1) && entry.budget <= budget_q) begin
            run_en     = 1'b1;
            await_d    = 1'b1;
            pos_d      = CNT_W'(pos_q + 1'b1);
            res_kind_d = rbtd_pkg::KIND_DISPATCH;
            res_slot_d = rbtd_pkg::SLOT_W'(pos_q);
            res_left_d = budget_q;
            state_d    = S_EMIT;
          end else begin
            pos_d   = CNT_W'(pos_q + 1'b1);
            state_d = S_SCAN_CHECK;
          end
        end
      end

      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = res_kind_q;
          out_slot_d  = res_slot_q;
          out_left_d  = res_left_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loop_rate_q <= rbtd_pkg::LOOP_RATE_RST;
      task_cnt_q  <= '0;
      tick_q      <= '0;
      loop_cnt_q  <= '0;
      pend_q      <= 1'b0;
      await_q     <= 1'b0;
      pos_q       <= '0;
      budget_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loop_rate_q <= loop_rate_d;
      task_cnt_q  <= task_cnt_d;
      tick_q      <= tick_d;
      loop_cnt_q  <= loop_cnt_d;
      pend_q      <= pend_d;
      await_q     <= await_d;
      pos_q       <= pos_d;
      budget_q    <= budget_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q  <= elapsed_d;
    res_kind_q <= res_kind_d;
    res_slot_q <= res_slot_d;
    res_left_q <= res_left_d;
    out_kind_q <= out_kind_d;
    out_slot_q <= out_slot_d;
    out_left_q <= out_left_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = out_kind_q;
  assign out_o.dispatch_slot = out_slot_q;
  assign out_o.time_left_us  = out_left_q;

  rbtd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rbtd_table #(
    .DEPTH (MAX_TASKS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_addr_i   (pos_q[IDX_W-1:0]),
    .ld_en_i     (ld_en),
    .ld_addr_i   (IDX_W'(in_i.task_slot)),
    .ld_rate_i   (in_i.task_rate_hz),
    .ld_budget_i (in_i.task_budget_us),
    .run_en_i    (run_en),
    .run_addr_i  (pos_q[IDX_W-1:0]),
    .run_loop_i  (loop_cnt_q),
    .entry_o     (entry)
  );

endmodule

`default_nettype wire
